@@ hdl/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

    // Field widths of the stream words
    localparam int REQ_W       = 3;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 4;
    localparam int CNT_OUT_W   = 5;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_NONE       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_FRONT,
        S_RD_BACK,
        S_RD_INDEX,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_FRONT,
        RD_BACK,
        RD_INDEX
    } t_rd_sel;

    typedef struct packed {
        logic    load_req;
        logic    exec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_front;
        logic    cap_back;
        logic    load_out;
    } t_dp_cmd;

endpackage

@@ hdl/deq_ctrl.sv @@
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output deq_pkg::t_dp_cmd o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_sel = deq_pkg::RD_FRONT;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = deq_pkg::S_RD_FRONT;
            end
            deq_pkg::S_RD_FRONT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = deq_pkg::RD_FRONT;
                n_state      = deq_pkg::S_RD_BACK;
            end
            deq_pkg::S_RD_BACK: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = deq_pkg::RD_BACK;
                o_cmd.cap_front = 1'b1;
                n_state         = deq_pkg::S_RD_INDEX;
            end
            deq_pkg::S_RD_INDEX: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = deq_pkg::RD_INDEX;
                o_cmd.cap_back = 1'b1;
                n_state        = deq_pkg::S_DONE;
            end
            deq_pkg::S_DONE: begin
                // wait for the output register to free up
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/deq_datapath.sv @@
`timescale 1ns / 1ps

module deq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_dp_cmd                    i_cmd,
    input  logic [deq_pkg::REQ_W-1:0]           i_req_type,
    input  logic [deq_pkg::VAL_W-1:0]           i_push_value,
    input  logic [deq_pkg::IDX_W-1:0]           i_read_index,
    output logic [deq_pkg::VAL_W-1:0]           o_front_value,
    output logic [deq_pkg::VAL_W-1:0]           o_back_value,
    output logic [deq_pkg::VAL_W-1:0]           o_read_value,
    output logic [deq_pkg::CNT_OUT_W-1:0]       o_entry_count,
    output logic                                o_is_empty,
    output logic [deq_pkg::STAT_W-1:0]          o_status
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int VW   = deq_pkg::VAL_W;
    localparam int IW   = deq_pkg::IDX_W;
    localparam int OCW  = deq_pkg::CNT_OUT_W;
    localparam int CMPW = (CW > IW) ? CW : IW;
    localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    function automatic logic [PW-1:0] f_slot(input logic [PW-1:0] base,
                                             input logic [PW-1:0] pos);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[PW-1:0];
    endfunction

    logic [DATA_WIDTH-1:0]       mem [DEPTH];
    logic [DATA_WIDTH-1:0]       r_rd_data;

    logic [deq_pkg::REQ_W-1:0]   r_req;
    logic [DATA_WIDTH-1:0]       r_push;
    logic [IW-1:0]               r_idx;
    logic [PW-1:0]               r_start;
    logic [CW-1:0]               r_count;
    logic [deq_pkg::STAT_W-1:0]  r_status;
    logic [DATA_WIDTH-1:0]       r_front;
    logic [DATA_WIDTH-1:0]       r_back;

    logic [PW-1:0]               n_start;
    logic [CW-1:0]               n_count;
    logic [deq_pkg::STAT_W-1:0]  n_status;
    logic                        w_wr_en;
    logic [PW-1:0]               w_wr_addr;
    logic [PW-1:0]               w_rd_addr;
    logic [PW-1:0]               w_start_dec;
    logic                        w_full;
    logic                        w_empty;

    assign w_full      = (r_count == DEPTH_C);
    assign w_empty     = (r_count == '0);
    assign w_start_dec = (r_start == '0) ? LAST_PTR : r_start - PW'(1);

    // apply one request to pointer and count
    always_comb begin
        n_start   = r_start;
        n_count   = r_count;
        n_status  = deq_pkg::ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = f_slot(r_start, PW'(r_count));
        case (r_req)
            deq_pkg::REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::REQ_PUSH_FRONT: begin
                w_wr_addr = w_start_dec;
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_start = w_start_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::REQ_POP_FRONT: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_start = f_slot(r_start, PW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::REQ_POP_BACK: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::REQ_READ: begin
                if (CMPW'(r_idx) >= CMPW'(r_count)) begin
                    n_status = deq_pkg::ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            deq_pkg::RD_FRONT: w_rd_addr = r_start;
            deq_pkg::RD_BACK:  w_rd_addr = f_slot(r_start, PW'(r_count - CW'(1)));
            deq_pkg::RD_INDEX: w_rd_addr = f_slot(r_start, PW'(r_idx));
            default:           w_rd_addr = r_start;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            mem[w_wr_addr] <= r_push;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_start <= n_start;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req_type;
            r_push <= DATA_WIDTH'(i_push_value);
            r_idx  <= i_read_index;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.cap_front) begin
            r_front <= r_rd_data;
        end
        if (i_cmd.cap_back) begin
            r_back <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            o_front_value <= w_empty ? '0 : VW'(r_front);
            o_back_value  <= w_empty ? '0 : VW'(r_back);
            o_read_value  <= (r_req == deq_pkg::REQ_READ && r_status == deq_pkg::ST_OK)
                             ? VW'(r_rd_data) : '0;
            o_entry_count <= OCW'(r_count);
            o_is_empty    <= w_empty;
            o_status      <= r_status;
        end
    end

endmodule

@@ hdl/double_ended_queue.sv @@
`timescale 1ns / 1ps

// Bounded double-ended queue on a ring buffer of DEPTH words. Each input word carries one
// request (tuser): none, push back, push front, pop front, pop back, or read the entry at a
// position counted from the front; each request yields exactly one output word reporting
// front, back and read values, the count, an empty flag and a status (tuser). Pushing onto
// a full queue is refused, popping an empty queue is flagged, and a read past the count
// returns zero with an out-of-range status; in each of those cases the queue is left as is.
// One request is in flight at a time: once accepted, it passes through execute, three
// store reads and hand over before its result is loaded into the output register, and no
// new request is taken meanwhile. The three reads are forced by the single read
// port of the entry store, which fetches front, back and indexed entries one after another.
// The output register holds a result while the sink stalls, and the next request is
// accepted in the cycle after the previous result has been loaded. No clearing pass after
// reset: store entries only reach the output once written.

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // push_value [31:0], read_index [35:32], zero pad [39:36]
    input  logic [deq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type [2:0]
    input  logic [deq_pkg::REQ_W-1:0]         s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // front_value [31:0], back_value [63:32], read_value [95:64],
    // entry_count [100:96], is_empty [101], zero pad [103:102]
    output logic [deq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [deq_pkg::STAT_W-1:0]        m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);

    deq_pkg::t_dp_cmd                  w_cmd;
    logic [deq_pkg::VAL_W-1:0]         w_front;
    logic [deq_pkg::VAL_W-1:0]         w_back;
    logic [deq_pkg::VAL_W-1:0]         w_read;
    logic [deq_pkg::CNT_OUT_W-1:0]     w_count;
    logic                              w_empty;

    // sequence each request: load, execute, three store reads, hand over
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    // pointer, count, entry store and output register
    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (s_axis_tuser),
        .i_push_value  (s_axis_tdata[31:0]),
        .i_read_index  (s_axis_tdata[35:32]),
        .o_front_value (w_front),
        .o_back_value  (w_back),
        .o_read_value  (w_read),
        .o_entry_count (w_count),
        .o_is_empty    (w_empty),
        .o_status      (m_axis_tuser)
    );

    // pack the result word, lowest field first
    assign m_axis_tdata = {2'b00, w_empty, w_count, w_read, w_back, w_front};

endmodule

@@ hdl/deq_checker.sv @@
`timescale 1ns / 1ps

module deq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic [deq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic [deq_pkg::REQ_W-1:0]         s_axis_tuser,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [deq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic [deq_pkg::STAT_W-1:0]        m_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request in flight: no back-to-back acceptance
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // empty queue shows zero count and zero front and back
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[101] |->
            m_axis_tdata[100:96] == 5'd0 && m_axis_tdata[63:0] == 64'd0)
        else $error("empty flag with non-zero contents");

    // a pop on an empty queue leaves it empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == deq_pkg::ST_EMPTY |-> m_axis_tdata[101])
        else $error("pop-on-empty status with entries held");

    // a non-zero read value only comes with a good status
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[95:64] != 32'd0 |-> m_axis_tuser == deq_pkg::ST_OK)
        else $error("read value with error status");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
